>>> hw/rtl/lpb_pkg.sv
package lpb_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int RANK_W    = SLOT_W;

  // request codes; six and seven mean nothing
  typedef enum logic [2:0] {
    REQ_ACCESS     = 3'd0,
    REQ_MARK_DIRTY = 3'd1,
    REQ_PROBE      = 3'd2,
    REQ_DISCARD    = 3'd3,
    REQ_FLUSH_PAGE = 3'd4,
    REQ_FLUSH_FILE = 3'd5
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DECIDE,
    ST_UPD_RD,
    ST_UPD_EV,
    ST_FLUSH_RD,
    ST_FLUSH_EV,
    ST_EMIT
  } state_t;

  // one slot entry: tag and recency rank
  typedef struct packed {
    logic [7:0]        file;
    logic [31:0]       page;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        dirty_flag;
    logic        load;
    logic        wb_valid;
    logic [7:0]  wb_file;
    logic [31:0] wb_page;
    logic        not_found;
    logic        last;
  } rsp_t;

endpackage

>>> hw/rtl/lpb_if.sv
interface lpb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  file_id;
  logic [31:0] page_num;

  modport source (output valid, req_type, file_id, page_num, input ready);
  modport sink   (input valid, req_type, file_id, page_num, output ready);
endinterface

interface lpb_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  slot;
  logic        dirty_flag;
  logic        load;
  logic        wb_valid;
  logic [7:0]  wb_file;
  logic [31:0] wb_page;
  logic        not_found;
  logic        last;

  modport source (output valid, hit, slot, dirty_flag, load, wb_valid, wb_file, wb_page,
                  not_found, last, input ready);
  modport sink   (input valid, hit, slot, dirty_flag, load, wb_valid, wb_file, wb_page,
                  not_found, last, output ready);
endinterface

>>> hw/rtl/lpb_tag_ram.sv
module lpb_tag_ram
  import lpb_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [NUM_SLOTS];

  // single write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> hw/rtl/lru_page_buffer_controller.sv
// sequencing: every request takes a scan pass over all slots, a read state and an
// evaluate state a slot; access and a discard that hits add a rank update pass;
// flush file adds a flush pass up to the last dirty page of the file, if it has one.
// throughput: one request at a time; the next is accepted only after the last result
// word of the current one loads into the output register, which waits while stalled.
// reset: synchronous active-low; clears used and dirty bits and control state.
module lru_page_buffer_controller
  import lpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lpb_req_if.sink   in_req,
  lpb_rsp_if.source out_rsp
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0]    idx_r;
  logic [2:0]           kind_r;
  logic [7:0]           file_r;
  logic [31:0]          page_r;
  logic [NUM_SLOTS-1:0] used_r, dirty_r;
  logic                 found_r, free_found_r, any_r;
  logic [SLOT_W-1:0]    s_r, free_r, vict_r, last_idx_r, tgt_r;
  logic [RANK_W-1:0]    srank_r, best_r, lim_r;
  logic [7:0]           vict_file_r;
  logic [31:0]          vict_page_r;
  logic                 inc_all_r, dec_r;
  rsp_t                 res_r, res_nxt, out_r;
  logic                 out_valid_r;

  ram_req_t ram_req;
  entry_t   rd;

  lpb_tag_ram u_ram (.clk(clk), .req(ram_req), .rdata(rd));

  logic in_acc, out_free, last_slot, tag_eq, flush_match;
  logic upd_needed;
  logic miss_fill;
  logic [SLOT_W-1:0] miss_slot;
  entry_t upd_word;
  rsp_t   flush_word;

  assign in_acc      = in_req.valid && in_req.ready;
  assign out_free    = !out_valid_r || out_rsp.ready;
  assign last_slot   = (idx_r == LAST_IDX);
  assign tag_eq      = (rd.file == file_r) && (rd.page == page_r);
  assign flush_match = used_r[idx_r] && dirty_r[idx_r] && (rd.file == file_r);
  assign miss_slot   = free_found_r ? free_r : vict_r;
  assign miss_fill   = (kind_r == 3'(REQ_ACCESS)) && !found_r;

  // decision after the scan pass
  always_comb begin
    res_nxt      = '0;
    res_nxt.last = 1'b1;
    upd_needed   = 1'b0;
    if (kind_r <= 3'(REQ_FLUSH_PAGE)) begin
      res_nxt.hit  = found_r;
      res_nxt.slot = found_r ? 6'(s_r) : '0;
    end
    case (kind_r)
      REQ_ACCESS: begin
        upd_needed = 1'b1;
        if (!found_r) begin
          res_nxt.slot = 6'(miss_slot);
          res_nxt.load = 1'b1;
          if (!free_found_r && dirty_r[vict_r]) begin
            res_nxt.wb_valid = 1'b1;
            res_nxt.wb_file  = vict_file_r;
            res_nxt.wb_page  = vict_page_r;
          end
        end
      end
      REQ_MARK_DIRTY: res_nxt.not_found = !found_r;
      REQ_PROBE:      res_nxt.dirty_flag = found_r && dirty_r[s_r];
      REQ_DISCARD:    upd_needed = found_r;
      REQ_FLUSH_PAGE: begin
        if (found_r && dirty_r[s_r]) begin
          res_nxt.wb_valid = 1'b1;
          res_nxt.wb_file  = file_r;
          res_nxt.wb_page  = page_r;
        end
      end
      default: ;
    endcase
  end

  // tag and rank rewrite for one slot
  always_comb begin
    upd_word = rd;
    if (idx_r == tgt_r) begin
      upd_word.file = file_r;
      upd_word.page = page_r;
      upd_word.rank = '0;
    end else if (used_r[idx_r]) begin
      if (dec_r) begin
        if (rd.rank > lim_r) upd_word.rank = rd.rank - 1'b1;
      end else if (inc_all_r || rd.rank < lim_r) begin
        upd_word.rank = rd.rank + 1'b1;
      end
    end
  end

  // write-back word of the flush file pass
  always_comb begin
    flush_word          = '0;
    flush_word.hit      = 1'b1;
    flush_word.slot     = 6'(idx_r);
    flush_word.wb_valid = 1'b1;
    flush_word.wb_file  = rd.file;
    flush_word.wb_page  = rd.page;
    flush_word.last     = (idx_r == last_idx_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = ST_SCAN_EV;
      ST_SCAN_EV:  state_nxt = last_slot ? ST_DECIDE : ST_SCAN_RD;
      ST_DECIDE: begin
        if (kind_r == 3'(REQ_FLUSH_FILE)) begin
          state_nxt = any_r ? ST_FLUSH_RD : ST_EMIT;
        end else begin
          state_nxt = upd_needed ? ST_UPD_RD : ST_EMIT;
        end
      end
      ST_UPD_RD:   state_nxt = ST_UPD_EV;
      ST_UPD_EV:   state_nxt = last_slot ? ST_EMIT : ST_UPD_RD;
      ST_FLUSH_RD: state_nxt = ST_FLUSH_EV;
      ST_FLUSH_EV: begin
        if (!flush_match) begin
          state_nxt = ST_FLUSH_RD;
        end else if (out_free) begin
          state_nxt = (idx_r == last_idx_r) ? ST_IDLE : ST_FLUSH_RD;
        end
      end
      ST_EMIT:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_req.ready  = (state_r == ST_IDLE);
    ram_req       = '0;
    ram_req.re    = (state_r == ST_SCAN_RD) || (state_r == ST_UPD_RD) ||
                    (state_r == ST_FLUSH_RD);
    ram_req.raddr = idx_r;
    ram_req.we    = (state_r == ST_UPD_EV);
    ram_req.waddr = idx_r;
    ram_req.wdata = upd_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture, scan bookkeeping and slot updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      dirty_r <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            kind_r       <= in_req.req_type;
            file_r       <= in_req.file_id;
            page_r       <= in_req.page_num;
            idx_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            any_r        <= 1'b0;
            best_r       <= '0;
            vict_r       <= '0;
            s_r          <= '0;
            srank_r      <= '0;
          end
        end
        ST_SCAN_EV: begin
          if (used_r[idx_r] && tag_eq && !found_r) begin
            found_r <= 1'b1;
            s_r     <= idx_r;
            srank_r <= rd.rank;
          end
          if (!used_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_r       <= idx_r;
          end
          if (used_r[idx_r] && rd.rank >= best_r) begin
            best_r      <= rd.rank;
            vict_r      <= idx_r;
            vict_file_r <= rd.file;
            vict_page_r <= rd.page;
          end
          if (flush_match) begin
            any_r      <= 1'b1;
            last_idx_r <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        ST_DECIDE: begin
          res_r     <= res_nxt;
          idx_r     <= '0;
          inc_all_r <= miss_fill;
          dec_r     <= (kind_r == 3'(REQ_DISCARD));
          lim_r     <= srank_r;
          tgt_r     <= miss_fill ? miss_slot : s_r;
          case (kind_r)
            REQ_ACCESS: begin
              if (!found_r) begin
                used_r[miss_slot]  <= 1'b1;
                dirty_r[miss_slot] <= 1'b0;
              end
            end
            REQ_MARK_DIRTY: if (found_r) dirty_r[s_r] <= 1'b1;
            REQ_DISCARD: begin
              if (found_r) begin
                used_r[s_r]  <= 1'b0;
                dirty_r[s_r] <= 1'b0;
              end
            end
            REQ_FLUSH_PAGE: if (found_r) dirty_r[s_r] <= 1'b0;
            default: ;
          endcase
        end
        ST_UPD_EV: idx_r <= idx_r + 1'b1;
        ST_FLUSH_EV: begin
          if (!flush_match) begin
            idx_r <= idx_r + 1'b1;
          end else if (out_free) begin
            dirty_r[idx_r] <= 1'b0;
            idx_r          <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= res_r;
    end else if (state_r == ST_FLUSH_EV && flush_match && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= flush_word;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.hit        = out_r.hit;
  assign out_rsp.slot       = out_r.slot;
  assign out_rsp.dirty_flag = out_r.dirty_flag;
  assign out_rsp.load       = out_r.load;
  assign out_rsp.wb_valid   = out_r.wb_valid;
  assign out_rsp.wb_file    = out_r.wb_file;
  assign out_rsp.wb_page    = out_r.wb_page;
  assign out_rsp.not_found  = out_r.not_found;
  assign out_rsp.last       = out_r.last;

endmodule

>>> hw/rtl/lpb_checker.sv
module lpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic        dirty_flag,
  input logic        load,
  input logic        wb_valid,
  input logic        not_found,
  input logic        last,
  input logic [31:0] wb_page
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(wb_page) && $stable(last))
    else $error("result word changed while stalled");

  // a load only follows a miss
  a_load_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && load |-> !hit && !not_found)
    else $error("load reported on a hit");

  // a missing page is a single final word
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && not_found |-> !hit && last && !wb_valid)
    else $error("bad not found word");

  // dirty report only for resident pages
  a_dirty_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dirty_flag |-> hit && !load)
    else $error("dirty flag without hit");

endmodule

bind lru_page_buffer_controller lpb_checker u_lpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .hit        (out_rsp.hit),
  .dirty_flag (out_rsp.dirty_flag),
  .load       (out_rsp.load),
  .wb_valid   (out_rsp.wb_valid),
  .not_found  (out_rsp.not_found),
  .last       (out_rsp.last),
  .wb_page    (out_rsp.wb_page)
);

>>> tb/sv/tb_lpb_if_note.sv
// channel interfaces come from the rtl (lpb_if.sv); this file holds the
// testbench word types shared by the bench
package tb_lpb_types;
  import lpb_pkg::*;

  // one request word
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  file;
    logic [31:0] page;
  } req_word_t;
endpackage

>>> tb/sv/tb.sv
module tb;
  import lpb_pkg::*;
  import tb_lpb_types::*;

  localparam int STALL_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 8 * NUM_SLOTS + 40;
  localparam int WATCHDOG_LIMIT = 60 * NUM_SLOTS + 2000;

  logic clk;
  logic rst_n;

  lpb_req_if req_ch ();
  lpb_rsp_if rsp_ch ();

  lru_page_buffer_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_rsp(rsp_ch.source)
  );

  // page table mirror
  logic        m_used  [NUM_SLOTS];
  logic        m_dirty [NUM_SLOTS];
  logic [7:0]  m_file  [NUM_SLOTS];
  logic [31:0] m_page  [NUM_SLOTS];
  int          m_rank  [NUM_SLOTS];

  rsp_t pending_rsp[$];
  int   mismatch_count;
  int   idle_cycles;
  bit   hold_rsp;
  bit   no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // append one expected result word
  function automatic void queue_word(rsp_t r);
    pending_rsp = {pending_rsp, r};
  endfunction

  // move every used slot ranked below old back one, put s in front
  function automatic void make_recent(int s, int old);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (m_used[i] && i != s && m_rank[i] < old) m_rank[i] = (m_rank[i] + 1) & 63;
    end
    m_rank[s] = 0;
  endfunction

  function automatic rsp_t blank_rsp();
    rsp_t r;
    r = '0;
    return r;
  endfunction

  // predict the result words of one request and update the mirror
  function automatic void predict_page_table(req_word_t w);
    rsp_t r;
    int   s;
    int   n;
    int   victim;
    int   best;
    r = blank_rsp();
    r.last = 1'b1;
    if (w.kind == REQ_FLUSH_FILE) begin
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (m_used[i] && m_dirty[i] && m_file[i] == w.file) begin
          if (n > 0) queue_word(r);
          r = blank_rsp();
          r.hit = 1'b1;
          r.slot = i[5:0];
          r.wb_valid = 1'b1;
          r.wb_file = m_file[i];
          r.wb_page = m_page[i];
          m_dirty[i] = 1'b0;
          n++;
        end
      end
      r.last = 1'b1;
      queue_word(r);
      return;
    end
    if (w.kind > REQ_FLUSH_FILE) begin
      queue_word(r);
      return;
    end
    s = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (s < 0 && m_used[i] && m_file[i] == w.file && m_page[i] == w.page) s = i;
    end
    if (s >= 0) begin
      r.hit = 1'b1;
      r.slot = s[5:0];
    end
    case (w.kind)
      REQ_ACCESS: begin
        if (s >= 0) begin
          make_recent(s, m_rank[s]);
        end else begin
          victim = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (victim < 0 && !m_used[i]) victim = i;
          end
          if (victim < 0) begin
            best = 0;
            victim = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (m_rank[i] >= best) begin
                best = m_rank[i];
                victim = i;
              end
            end
            if (m_dirty[victim]) begin
              r.wb_valid = 1'b1;
              r.wb_file = m_file[victim];
              r.wb_page = m_page[victim];
            end
          end else begin
            m_used[victim] = 1'b1;
          end
          make_recent(victim, NUM_SLOTS);
          m_file[victim] = w.file;
          m_page[victim] = w.page;
          m_dirty[victim] = 1'b0;
          r.slot = victim[5:0];
          r.load = 1'b1;
        end
      end
      REQ_MARK_DIRTY: begin
        if (s >= 0) m_dirty[s] = 1'b1;
        else r.not_found = 1'b1;
      end
      REQ_PROBE: begin
        if (s >= 0) r.dirty_flag = m_dirty[s];
      end
      REQ_DISCARD: begin
        if (s >= 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (m_used[i] && i != s && m_rank[i] > m_rank[s]) m_rank[i]--;
          end
          m_used[s] = 1'b0;
          m_dirty[s] = 1'b0;
          m_rank[s] = 0;
        end
      end
      default: begin
        if (s >= 0 && m_dirty[s]) begin
          r.wb_valid = 1'b1;
          r.wb_file = m_file[s];
          r.wb_page = m_page[s];
          m_dirty[s] = 1'b0;
        end
      end
    endcase
    queue_word(r);
  endfunction

  // send one request word, with a random gap ahead of it
  task automatic send_req(logic [2:0] kind, logic [7:0] file, logic [31:0] page);
    req_word_t w;
    int        gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = kind;
    req_ch.file_id = file;
    req_ch.page_num = page;
    w.kind = kind;
    w.file = file;
    w.page = page;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_page_table(w);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // small working set so hits, evictions and dirty pages are common
  function automatic logic [7:0] pick_file();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] pick_page();
    return ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 40));
  endfunction

  // extremes of the fields, every request kind and each special case
  task automatic test_directed();
    send_req(REQ_MARK_DIRTY, 8'hff, 32'hffff_ffff);
    send_req(REQ_PROBE, 8'h00, 32'h0);
    send_req(REQ_DISCARD, 8'h00, 32'h0);
    send_req(REQ_FLUSH_PAGE, 8'h00, 32'h0);
    send_req(REQ_FLUSH_FILE, 8'h00, 32'h0);
    send_req(REQ_ACCESS, 8'hff, 32'hffff_ffff);
    send_req(REQ_ACCESS, 8'h00, 32'h0);
    send_req(REQ_ACCESS, 8'hff, 32'hffff_ffff);
    send_req(REQ_MARK_DIRTY, 8'hff, 32'hffff_ffff);
    send_req(REQ_PROBE, 8'hff, 32'hffff_ffff);
    send_req(REQ_PROBE, 8'h00, 32'h0);
    send_req(REQ_FLUSH_PAGE, 8'hff, 32'hffff_ffff);
    send_req(REQ_MARK_DIRTY, 8'h00, 32'h0);
    send_req(REQ_DISCARD, 8'h00, 32'h0);
    send_req(3'd6, 8'h5a, 32'h1234_5678);
    send_req(3'd7, 8'ha5, 32'hedcb_a987);
    send_req(REQ_ACCESS, 8'h01, 32'h1);
    send_req(REQ_MARK_DIRTY, 8'hff, 32'hffff_ffff);
    send_req(REQ_FLUSH_FILE, 8'hff, 32'h0);
    send_req(REQ_FLUSH_FILE, 8'hff, 32'h0);
  endtask

  // fill all slots, dirty one file, then evict and flush it
  task automatic test_eviction();
    for (int i = 0; i < NUM_SLOTS + 4; i++) begin
      send_req(REQ_ACCESS, 8'h20, 32'(i + 100));
      if (i % 2 == 0) send_req(REQ_MARK_DIRTY, 8'h20, 32'(i + 100));
    end
    for (int i = 0; i < 6; i++) send_req(REQ_ACCESS, 8'h21, 32'(i));
    send_req(REQ_FLUSH_FILE, 8'h20, 32'h0);
  endtask

  // receiver holds off while requests keep coming, then the sender pauses
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    no_gaps = 1'b1;
    fork
      begin
        repeat (STALL_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_req(REQ_PROBE, pick_file(), pick_page());
    join
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i / 40) % 3 == 1;
      k = $urandom_range(0, 99);
      if (k < 45) send_req(REQ_ACCESS, pick_file(), pick_page());
      else if (k < 62) send_req(REQ_MARK_DIRTY, pick_file(), pick_page());
      else if (k < 72) send_req(REQ_PROBE, pick_file(), pick_page());
      else if (k < 80) send_req(REQ_DISCARD, pick_file(), pick_page());
      else if (k < 88) send_req(REQ_FLUSH_PAGE, pick_file(), pick_page());
      else if (k < 96) send_req(REQ_FLUSH_FILE, pick_file(), $urandom);
      else send_req(3'($urandom_range(6, 7)), 8'($urandom), $urandom);
    end
    no_gaps = 1'b0;
  endtask

  // result side: random wait per word, compare against the oldest expected word
  initial begin
    rsp_t exp_rsp;
    rsp_t got;
    int   wait_left;
    rsp_ch.ready = 1'b0;
    wait_left = $urandom_range(0, 16);
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        rsp_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        wait_left = no_gaps ? 0 : $urandom_range(0, 16);
        got.hit = rsp_ch.hit;
        got.slot = rsp_ch.slot;
        got.dirty_flag = rsp_ch.dirty_flag;
        got.load = rsp_ch.load;
        got.wb_valid = rsp_ch.wb_valid;
        got.wb_file = rsp_ch.wb_file;
        got.wb_page = rsp_ch.wb_page;
        got.not_found = rsp_ch.not_found;
        got.last = rsp_ch.last;
        if (pending_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result word %p", got);
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (got !== exp_rsp) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("expected %p got %p", exp_rsp, got);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT + STALL_CYCLES) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.file_id = '0;
    req_ch.page_num = '0;
    hold_rsp = 1'b0;
    no_gaps = 1'b0;
    mismatch_count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m_used[i] = 1'b0;
      m_dirty[i] = 1'b0;
      m_file[i] = '0;
      m_page[i] = '0;
      m_rank[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_eviction();
    test_backpressure();
    test_random(290);
    wait_drained();
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
